/* hdl/pngenc_pkg.sv */
// Shared types, constants and helper functions of the PNG stored-RGBA encoder.
`timescale 1ns / 1ps

package pngenc_pkg;

	localparam int          QUEUE_DEPTH_DEF = 4;
	localparam logic [14:0] MAX_DIM         = 15'd16384;
	localparam logic [15:0] BLOCK_BYTES     = 16'hFFFF;
	localparam logic [15:0] ADLER_MOD       = 16'd65521;
	localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic {
		KIND_START,
		KIND_PIXEL
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [23:0] rgb;
	} queue_item_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [14:0] clamp_dim(input logic [14:0] v);
		logic [14:0] r;
		if (v == 15'd0) begin
			r = 15'd1;
		end else if (v > MAX_DIM) begin
			r = MAX_DIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hdl/pngenc_front.sv */
// Front end: accepts input transactions, tags them by kind and queues them for the back end.
`timescale 1ns / 1ps

module pngenc_front import pngenc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [23:0] pixel_rgb,
	output logic        q_valid,
	output queue_item_t q_item,
	input  logic        q_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	queue_item_t    mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;
	queue_item_t    new_item;

	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		new_item.kind = (cmd == CMD_START) ? KIND_START : KIND_PIXEL;
		new_item.rgb  = pixel_rgb;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/pngenc_back.sv */
// Back end: byte sequencer that turns queued items into the PNG stream with CRC and Adler-32.
`timescale 1ns / 1ps

module pngenc_back import pngenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [14:0] image_width,
	input  logic [14:0] image_height,
	input  logic        q_valid,
	input  queue_item_t q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        end_of_file
);

	typedef enum logic {
		PH_IDLE,
		PH_PIXELS
	} phase_t;

	// Item sequencing state
	logic        busy_q;
	item_kind_t  kind_q;
	logic [23:0] rgb_q;
	logic [5:0]  step_q;
	logic [2:0]  ri_q;
	logic [2:0]  hk_q;
	logic        hdr_done_q;
	logic        in_tail_q;
	logic [4:0]  tail_q;
	phase_t      phase_q;

	// Stream state
	logic [13:0] column_q;
	logic [13:0] row_q;
	logic [15:0] block_fill_q;
	logic [30:0] raw_rem_q;
	logic [15:0] adler_low_q;
	logic [15:0] adler_high_q;
	logic [31:0] crc_q;
	logic [14:0] lat_w_q;
	logic [14:0] lat_h_q;

	// Size arithmetic pipeline
	logic [30:0] raw_s1;
	logic [30:0] raw_s2;
	logic [15:0] blk_s2;
	logic [31:0] zlen_s3;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        eof_q;

	logic        adv;
	logic        skip;
	logic        emit;
	logic        done;
	logic        pop;
	logic [2:0]  eff_ri;
	logic [15:0] n_len;
	logic        in_hdr;
	logic        col_wrap;
	logic        row_wrap;
	logic [7:0]  cur_byte;
	logic        crc_en;
	logic        crc_rst;
	logic        is_last;
	logic        is_eof;
	logic [16:0] low_sum;
	logic [15:0] low_n;
	logic [16:0] high_sum;
	logic [15:0] high_n;
	logic [31:0] blk_x;
	logic [16:0] blk_ab;
	logic [15:0] blk_q0;
	logic [31:0] blk_r;
	logic [15:0] blk_q;
	logic [31:0] ihdr_crc;

	assign ihdr_crc = ~crc_q;

	// Number of stored blocks is ceil(raw / 65535); the estimate is off by at most one.
	always_comb begin
		blk_x  = 32'(raw_s1) + 32'(BLOCK_BYTES - 16'd1);
		blk_ab = {1'b0, blk_x[31:16]} + {1'b0, blk_x[15:0]};
		blk_q0 = blk_x[31:16] + 16'(blk_ab[16]);
		blk_r  = blk_x - {blk_q0, 16'h0} + 32'(blk_q0);
		blk_q  = (blk_r >= 32'(BLOCK_BYTES)) ? blk_q0 + 16'd1 : blk_q0;
	end

	always_ff @(posedge clk) begin
		raw_s1  <= 31'(32'(lat_h_q) * 32'({lat_w_q, 2'b01}));
		raw_s2  <= raw_s1;
		blk_s2  <= blk_q;
		zlen_s3 <= 32'd6 + 32'(raw_s2) + {14'h0, blk_s2, 2'b00} + 32'(blk_s2);
	end

	always_comb begin
		adv      = !out_valid_q || !out_stall;
		skip     = busy_q && (kind_q == KIND_PIXEL) && (phase_q == PH_IDLE);
		emit     = busy_q && !skip && adv;
		eff_ri   = (ri_q == 3'd0 && column_q != 14'd0) ? 3'd1 : ri_q;
		n_len    = (raw_rem_q < 31'(BLOCK_BYTES)) ? raw_rem_q[15:0] : BLOCK_BYTES;
		in_hdr   = (block_fill_q == 16'd0) && !hdr_done_q;
		col_wrap = ({1'b0, column_q} + 15'd1) >= lat_w_q;
		row_wrap = ({1'b0, row_q} + 15'd1) >= lat_h_q;

		cur_byte = 8'h00;
		crc_en   = 1'b0;
		crc_rst  = 1'b0;
		is_last  = 1'b0;
		is_eof   = 1'b0;

		if (kind_q == KIND_START) begin
			case (step_q)
				6'd0: cur_byte = 8'h89;
				6'd1: cur_byte = 8'h50;
				6'd2: cur_byte = 8'h4E;
				6'd3: cur_byte = 8'h47;
				6'd4: cur_byte = 8'h0D;
				6'd5: cur_byte = 8'h0A;
				6'd6: cur_byte = 8'h1A;
				6'd7: cur_byte = 8'h0A;
				6'd8, 6'd9, 6'd10: cur_byte = 8'h00;
				6'd11: cur_byte = 8'h0D;
				6'd12: begin cur_byte = 8'h49; crc_en = 1'b1; end
				6'd13: begin cur_byte = 8'h48; crc_en = 1'b1; end
				6'd14: begin cur_byte = 8'h44; crc_en = 1'b1; end
				6'd15: begin cur_byte = 8'h52; crc_en = 1'b1; end
				6'd16, 6'd17, 6'd18, 6'd19: begin
					cur_byte = word_byte({17'h0, lat_w_q}, step_q[1:0]);
					crc_en   = 1'b1;
				end
				6'd20, 6'd21, 6'd22, 6'd23: begin
					cur_byte = word_byte({17'h0, lat_h_q}, step_q[1:0]);
					crc_en   = 1'b1;
				end
				6'd24: begin cur_byte = 8'h08; crc_en = 1'b1; end
				6'd25: begin cur_byte = 8'h06; crc_en = 1'b1; end
				6'd26, 6'd27, 6'd28: begin cur_byte = 8'h00; crc_en = 1'b1; end
				6'd29, 6'd30, 6'd31, 6'd32: begin
					cur_byte = word_byte(ihdr_crc, 2'(step_q - 6'd29));
					crc_rst  = (step_q == 6'd32);
				end
				6'd33, 6'd34, 6'd35, 6'd36: begin
					cur_byte = word_byte(zlen_s3, 2'(step_q - 6'd33));
				end
				6'd37: begin cur_byte = 8'h49; crc_en = 1'b1; end
				6'd38: begin cur_byte = 8'h44; crc_en = 1'b1; end
				6'd39: begin cur_byte = 8'h41; crc_en = 1'b1; end
				6'd40: begin cur_byte = 8'h54; crc_en = 1'b1; end
				6'd41: begin cur_byte = 8'h78; crc_en = 1'b1; end
				6'd42: begin cur_byte = 8'h01; crc_en = 1'b1; is_last = 1'b1; end
				default: cur_byte = 8'h00;
			endcase
		end else if (in_tail_q) begin
			case (tail_q)
				5'd0, 5'd1, 5'd2, 5'd3: begin
					cur_byte = word_byte({adler_high_q, adler_low_q}, tail_q[1:0]);
					crc_en   = 1'b1;
				end
				5'd4, 5'd5, 5'd6, 5'd7: begin
					cur_byte = word_byte(ihdr_crc, tail_q[1:0]);
					crc_rst  = (tail_q == 5'd7);
				end
				5'd12: begin cur_byte = 8'h49; crc_en = 1'b1; end
				5'd13: begin cur_byte = 8'h45; crc_en = 1'b1; end
				5'd14: begin cur_byte = 8'h4E; crc_en = 1'b1; end
				5'd15: begin cur_byte = 8'h44; crc_en = 1'b1; end
				5'd16, 5'd17, 5'd18, 5'd19: begin
					cur_byte = word_byte(ihdr_crc, tail_q[1:0]);
					crc_rst  = (tail_q == 5'd19);
					is_last  = (tail_q == 5'd19);
					is_eof   = (tail_q == 5'd19);
				end
				default: cur_byte = 8'h00;
			endcase
		end else if (in_hdr) begin
			crc_en = 1'b1;
			case (hk_q)
				3'd0: cur_byte = {7'h0, (raw_rem_q <= 31'(BLOCK_BYTES))};
				3'd1: cur_byte = n_len[7:0];
				3'd2: cur_byte = n_len[15:8];
				3'd3: cur_byte = ~n_len[7:0];
				default: cur_byte = ~n_len[15:8];
			endcase
		end else begin
			crc_en = 1'b1;
			case (eff_ri)
				3'd0: cur_byte = 8'h00;
				3'd1: cur_byte = rgb_q[7:0];
				3'd2: cur_byte = rgb_q[15:8];
				3'd3: cur_byte = rgb_q[23:16];
				default: cur_byte = 8'hFF;
			endcase
			is_last = (eff_ri == 3'd4) && !(col_wrap && row_wrap);
		end

		low_sum  = {1'b0, adler_low_q} + {9'h0, cur_byte};
		low_n    = (low_sum >= {1'b0, ADLER_MOD}) ? 16'(low_sum - {1'b0, ADLER_MOD})
		                                          : low_sum[15:0];
		high_sum = {1'b0, adler_high_q} + {1'b0, low_n};
		high_n   = (high_sum >= {1'b0, ADLER_MOD}) ? 16'(high_sum - {1'b0, ADLER_MOD})
		                                           : high_sum[15:0];

		done = skip || (emit && is_last);
		pop  = q_valid && (!busy_q || done);
	end

	assign q_pop       = pop;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign end_of_file = eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			kind_q       <= KIND_START;
			rgb_q        <= '0;
			step_q       <= '0;
			ri_q         <= '0;
			hk_q         <= '0;
			hdr_done_q   <= 1'b0;
			in_tail_q    <= 1'b0;
			tail_q       <= '0;
			phase_q      <= PH_IDLE;
			column_q     <= '0;
			row_q        <= '0;
			block_fill_q <= '0;
			raw_rem_q    <= '0;
			adler_low_q  <= 16'd1;
			adler_high_q <= '0;
			crc_q        <= CRC_INIT;
			lat_w_q      <= 15'd1;
			lat_h_q      <= 15'd1;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			last_q       <= 1'b0;
			eof_q        <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= cur_byte;
				last_q      <= is_last;
				eof_q       <= is_eof;
				if (crc_rst) begin
					crc_q <= CRC_INIT;
				end else if (crc_en) begin
					crc_q <= crc32_byte(crc_q, cur_byte);
				end

				if (kind_q == KIND_START) begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd42) begin
						raw_rem_q <= raw_s2;
					end
				end else if (in_tail_q) begin
					tail_q <= tail_q + 5'd1;
					if (tail_q == 5'd19) begin
						phase_q <= PH_IDLE;
					end
				end else if (in_hdr) begin
					if (hk_q == 3'd4) begin
						hk_q         <= '0;
						hdr_done_q   <= 1'b1;
						block_fill_q <= n_len;
					end else begin
						hk_q <= hk_q + 3'd1;
					end
				end else begin
					adler_low_q  <= low_n;
					adler_high_q <= high_n;
					hdr_done_q   <= 1'b0;
					if (block_fill_q != 16'd0) begin
						block_fill_q <= block_fill_q - 16'd1;
					end
					if (raw_rem_q != 31'd0) begin
						raw_rem_q <= raw_rem_q - 31'd1;
					end
					if (eff_ri == 3'd4) begin
						if (col_wrap) begin
							column_q <= '0;
							if (row_wrap) begin
								row_q     <= '0;
								in_tail_q <= 1'b1;
								tail_q    <= '0;
							end else begin
								row_q <= row_q + 14'd1;
							end
						end else begin
							column_q <= column_q + 14'd1;
						end
					end else begin
						ri_q <= eff_ri + 3'd1;
					end
				end
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end

			// A new item loads after the current one's last byte, overriding its updates.
			if (pop) begin
				busy_q    <= 1'b1;
				kind_q    <= q_item.kind;
				rgb_q     <= q_item.rgb;
				step_q    <= '0;
				ri_q      <= '0;
				hk_q      <= '0;
				in_tail_q <= 1'b0;
				tail_q    <= '0;
				if (q_item.kind == KIND_START) begin
					lat_w_q      <= clamp_dim(image_width);
					lat_h_q      <= clamp_dim(image_height);
					crc_q        <= CRC_INIT;
					column_q     <= '0;
					row_q        <= '0;
					block_fill_q <= '0;
					hdr_done_q   <= 1'b0;
					adler_low_q  <= 16'd1;
					adler_high_q <= '0;
					phase_q      <= PH_PIXELS;
				end
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/png_stored_rgba_encoder.sv */
// An item's first byte passes the queue, the item registers and the output register.
// One output byte per cycle unless stalled, set by the single byte-wide output register.
// A start yields 43 bytes, a pixel 4 or 5 bytes plus 5 per stored-block header and 20
// after the last pixel; a pixel ignored while idle produces no byte.
// Reset clears all control state; both size registers reset to 1.
`timescale 1ns / 1ps

module png_stored_rgba_encoder import pngenc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [23:0] pixel_rgb,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        end_of_file
);

	logic [14:0] width_q;
	logic [14:0] height_q;
	logic        q_valid;
	queue_item_t q_item;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 15'd1;
			height_q <= 15'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	pngenc_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.pixel_rgb (pixel_rgb),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	pngenc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.end_of_file  (end_of_file)
	);

endmodule
